FILE: src/assert_macros.svh
// Assertion macros shared by the address walker RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked check, disabled during reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
  `ASSERT_AT(lbl, clk, rst, (pre) |-> (post), msg)

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  `ASSERT_AT(lbl, clk, rst, (pre) |=> (post), msg)

`endif

FILE: src/stawu_pkg.sv
// Package for the strided tensor address walker: widths, register codes,
// configuration and pipeline item types. No dependencies.
`timescale 1ns / 1ps

package stawu_pkg;

  localparam int MAX_RANK   = 4;
  localparam int NUM_DIMS   = 4;
  localparam int BASE_W     = 40;
  localparam int ESZ_W      = 2;
  localparam int RANK_W     = 3;
  localparam int STOR_W     = 40;
  localparam int DIM_W      = 56;
  localparam int EXT_W      = 24;
  localparam int STRIDE_W   = 32;
  localparam int IDX_W      = EXT_W;
  localparam int PROD_W     = IDX_W + STRIDE_W;
  localparam int SUM_W      = PROD_W + $clog2(MAX_RANK + 1);
  localparam int MAX_SHIFT  = (1 << ESZ_W) - 1;
  localparam int BYTES_W    = SUM_W + MAX_SHIFT;
  localparam int CHK_W      = BYTES_W + 1;
  localparam int ADDR_W     = 48;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE    = 3'd0,
    REG_ESZ     = 3'd1,
    REG_RANK    = 3'd2,
    REG_STORAGE = 3'd3,
    REG_DIM0    = 3'd4,
    REG_DIM1    = 3'd5,
    REG_DIM2    = 3'd6,
    REG_DIM3    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [BASE_W-1:0]                base;
    logic [ESZ_W-1:0]                 esz_log2;
    logic [RANK_W-1:0]                rank;
    logic [STOR_W-1:0]                storage;
    logic [NUM_DIMS-1:0][DIM_W-1:0]   dims;
  } cfg_t;

  // Indices of one element, already masked to the dimensions in use.
  typedef struct packed {
    logic [MAX_RANK-1:0][IDX_W-1:0] idx;
    logic                           last;
    logic                           empty;
  } walk_item_t;

  function automatic logic [EXT_W-1:0] extent_of(input logic [DIM_W-1:0] dim);
    return dim[STRIDE_W +: EXT_W];
  endfunction

  function automatic logic [STRIDE_W-1:0] stride_of(input logic [DIM_W-1:0] dim);
    return dim[STRIDE_W-1:0];
  endfunction

endpackage

FILE: src/stawu_channels.sv
// Valid/ready channel interfaces for the walker: request and result.
// Depends on stawu_pkg for field widths.
`timescale 1ns / 1ps

interface stawu_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface stawu_rsp_if;
  import stawu_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] byte_address;
  logic              last_element;
  logic              empty_tensor;
  logic              out_of_range;

  modport source (output valid, output byte_address, output last_element,
                  output empty_tensor, output out_of_range, input ready);
  modport sink   (input valid, input byte_address, input last_element,
                  input empty_tensor, input out_of_range, output ready);
endinterface

FILE: src/stawu_cfg_regs.sv
// Configuration register bank of the address walker.
// Depends on stawu_pkg.
`timescale 1ns / 1ps

module stawu_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [stawu_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [stawu_pkg::CFG_DATA_W-1:0] wr_data,
  output stawu_pkg::cfg_t                 cfg
);
  import stawu_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_BASE:    cfg.base     <= wr_data[BASE_W-1:0];
        REG_ESZ:     cfg.esz_log2 <= wr_data[ESZ_W-1:0];
        REG_RANK:    cfg.rank     <= wr_data[RANK_W-1:0];
        REG_STORAGE: cfg.storage  <= wr_data[STOR_W-1:0];
        REG_DIM0:    cfg.dims[0]  <= wr_data[DIM_W-1:0];
        REG_DIM1:    cfg.dims[1]  <= wr_data[DIM_W-1:0];
        REG_DIM2:    cfg.dims[2]  <= wr_data[DIM_W-1:0];
        REG_DIM3:    cfg.dims[3]  <= wr_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/stawu_index_walker.sv
// Index counters and row-major carry chain; registers one element's indices.
// Depends on stawu_pkg, stawu_channels and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stawu_index_walker (
  input  logic                 clk,
  input  logic                 rst,
  input  stawu_pkg::cfg_t      cfg,
  stawu_req_if.sink            req,
  output stawu_pkg::walk_item_t s1,
  output logic                 s1_valid,
  input  logic                 s1_ready
);
  import stawu_pkg::*;

  logic [MAX_RANK-1:0][IDX_W-1:0] cnt;
  logic [MAX_RANK-1:0][IDX_W-1:0] cnt_next;
  logic [MAX_RANK-1:0][IDX_W-1:0] cur;
  logic [MAX_RANK-1:0]            in_use;
  logic [MAX_RANK-1:0]            wrap;
  logic [RANK_W-1:0]              r_use;
  logic                           empty_c;
  logic                           last_c;
  logic                           carry;
  logic                           acc;
  walk_item_t                     item;

  assign req.ready = !s1_valid || s1_ready;
  assign acc       = req.valid && req.ready;

  always_comb begin
    logic [IDX_W:0] nxt;
    logic [EXT_W-1:0] ext;
    r_use    = (cfg.rank > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : cfg.rank;
    empty_c  = 1'b0;
    cnt_next = '0;
    item     = '0;
    carry    = 1'b1;
    for (int d = 0; d < MAX_RANK; d++) begin
      in_use[d] = RANK_W'(d) < r_use;
      cur[d]    = req.restart ? '0 : cnt[d];
      ext       = extent_of(cfg.dims[d]);
      nxt       = {1'b0, cur[d]} + (IDX_W+1)'(1);
      wrap[d]   = nxt >= {1'b0, ext};
      if (in_use[d] && (ext == '0)) empty_c = 1'b1;
    end
    // Innermost in-use dimension first; carry ripples outward.
    for (int d = MAX_RANK - 1; d >= 0; d--) begin
      cnt_next[d] = cur[d];
      if (in_use[d] && carry) begin
        cnt_next[d] = wrap[d] ? '0 : (cur[d] + IDX_W'(1));
      end
      carry = carry && (wrap[d] || !in_use[d]);
    end
    last_c = carry;
    if (empty_c) cnt_next = '0;
    for (int d = 0; d < MAX_RANK; d++) begin
      item.idx[d] = (in_use[d] && !empty_c) ? cur[d] : '0;
    end
    item.last  = last_c && !empty_c;
    item.empty = empty_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (acc) cnt <= cnt_next;
      if (req.ready) s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) s1 <= item;
  end

  `ASSERT_NEXT(a_empty_clears, clk, rst, acc && empty_c, cnt == '0,
               "counters not cleared after empty item")
  `ASSERT_IMPL(a_empty_not_last, clk, rst, s1_valid && s1.empty, !s1.last,
               "empty item flagged as last")
  `ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_ready,
               s1_valid && $stable(s1), "stalled index stage changed")

endmodule

FILE: src/stawu_addr_pipe.sv
// Address pipeline: products, sum with base, scale, saturate, bounds check.
// Depends on stawu_pkg, stawu_channels and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stawu_addr_pipe (
  input  logic                  clk,
  input  logic                  rst,
  input  stawu_pkg::cfg_t       cfg,
  input  stawu_pkg::walk_item_t s1,
  input  logic                  s1_valid,
  output logic                  s1_ready,
  stawu_rsp_if.source           rsp
);
  import stawu_pkg::*;

  logic [MAX_RANK-1:0][PROD_W-1:0] s2_prod;
  logic                            s2_last;
  logic                            s2_empty;
  logic                            v2;
  logic [SUM_W-1:0]                s3_sum;
  logic                            s3_last;
  logic                            s3_empty;
  logic                            v3;
  logic [ADDR_W-1:0]               out_addr;
  logic                            out_last;
  logic                            out_empty;
  logic                            out_oor;
  logic                            v4;
  logic                            ready2;
  logic                            ready3;
  logic                            ready4;
  logic [SUM_W-1:0]                sum_c;
  logic [BYTES_W-1:0]              bytes_c;
  logic [CHK_W-1:0]                end_c;
  logic [ADDR_W-1:0]               addr_c;
  logic                            oor_c;

  // Each stage moves on when it is empty or the one after it moves.
  assign ready4   = !v4 || rsp.ready;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign s1_ready = ready2;

  always_comb begin
    sum_c = SUM_W'(cfg.base);
    for (int d = 0; d < MAX_RANK; d++) begin
      sum_c = sum_c + SUM_W'(s2_prod[d]);
    end
  end

  always_comb begin
    bytes_c = BYTES_W'(s3_sum) << cfg.esz_log2;
    end_c   = CHK_W'(bytes_c) + (CHK_W'(1) << cfg.esz_log2);
    oor_c   = end_c > CHK_W'(cfg.storage);
    addr_c  = (bytes_c[BYTES_W-1:ADDR_W] != '0) ? '1 : bytes_c[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready2) v2 <= s1_valid;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      for (int d = 0; d < MAX_RANK; d++) begin
        s2_prod[d] <= PROD_W'(s1.idx[d]) * PROD_W'(stride_of(cfg.dims[d]));
      end
      s2_last  <= s1.last;
      s2_empty <= s1.empty;
    end
    if (ready3 && v2) begin
      s3_sum   <= sum_c;
      s3_last  <= s2_last;
      s3_empty <= s2_empty;
    end
    if (ready4 && v3) begin
      out_addr  <= s3_empty ? '0 : addr_c;
      out_last  <= s3_last && !s3_empty;
      out_empty <= s3_empty;
      out_oor   <= oor_c && !s3_empty;
    end
  end

  assign rsp.valid        = v4;
  assign rsp.byte_address = out_addr;
  assign rsp.last_element = out_last;
  assign rsp.empty_tensor = out_empty;
  assign rsp.out_of_range = out_oor;

  `ASSERT_IMPL(a_empty_zero, clk, rst, v4 && out_empty,
               (out_addr == '0) && !out_last && !out_oor,
               "empty result carries address or flags")
  `ASSERT_NEXT(a_s2_hold, clk, rst, v2 && !ready3,
               v2 && $stable(s2_prod) && $stable(s2_empty), "stalled product stage changed")
  `ASSERT_NEXT(a_s3_hold, clk, rst, v3 && !ready4,
               v3 && $stable(s3_sum) && $stable(s3_empty), "stalled sum stage changed")

endmodule

FILE: src/strided_tensor_address_walker_unit.sv
// Top level of the strided tensor address walker.
// Depends on stawu_pkg, stawu_channels, stawu_cfg_regs, stawu_index_walker, stawu_addr_pipe.
`timescale 1ns / 1ps

// Usage:
//   req carries one item per element request; restart=1 rewinds the walk to
//   element 0 before this item, restart=0 advances to the next element.
//   rsp returns one item per request, in order: the saturated byte address,
//   last-element, empty-tensor and out-of-range flags.
//   Configuration is written through wr_en/wr_index/wr_data while no item
//   is in flight; index i selects the i-th register of the register map.
// Pipeline: a taken request passes through the index stage, product stage,
//   sum stage and output register, in that order.
// Throughput: one item per cycle while rsp keeps taking results; the index
//   counters update in the same cycle the request is taken, and the four
//   per-dimension multipliers sit in their own pipeline stage.
// Reset: clears configuration, index counters and all stage valid bits.
// Stall: when rsp is not taken, the output register holds; earlier stages
//   keep filling until every stage is full, then req.ready drops.
module strided_tensor_address_walker_unit (
  input  logic                             clk,
  input  logic                             rst,
  stawu_req_if.sink                        req,
  stawu_rsp_if.source                      rsp,
  input  logic                             wr_en,
  input  logic [stawu_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [stawu_pkg::CFG_DATA_W-1:0] wr_data
);
  import stawu_pkg::*;

  cfg_t       cfg;
  walk_item_t s1;
  logic       s1_valid;
  logic       s1_ready;

  // Register bank: the user must keep it held stable while items are in flight; the bank does not enforce this.
  stawu_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // Advance the index counters and register the element's indices.
  stawu_index_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req      (req),
    .s1       (s1),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready)
  );

  // Turn indices into a byte address and flags.
  stawu_addr_pipe u_addr (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1       (s1),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .rsp      (rsp)
  );

endmodule
